// File: hw/rtl/itrn_pkg.sv
// package with payload types, letter codes and the digit pattern function
package itrn_pkg;

   localparam int VALUE_W    = 13;
   localparam int SYMBOL_W   = 7;
   localparam int GROUP_CH   = 4;
   localparam int WORD_CH    = 15;
   localparam int CNT_W      = 3;
   localparam int IDX_W      = 4;

   localparam logic [11:0] VALUE_LIMIT = 12'd4000;

   localparam logic [SYMBOL_W-1:0] CHAR_NONE = 7'h00;
   localparam logic [SYMBOL_W-1:0] CHAR_I    = 7'h49;
   localparam logic [SYMBOL_W-1:0] CHAR_V    = 7'h56;
   localparam logic [SYMBOL_W-1:0] CHAR_X    = 7'h58;
   localparam logic [SYMBOL_W-1:0] CHAR_L    = 7'h4c;
   localparam logic [SYMBOL_W-1:0] CHAR_C    = 7'h43;
   localparam logic [SYMBOL_W-1:0] CHAR_D    = 7'h44;
   localparam logic [SYMBOL_W-1:0] CHAR_M    = 7'h4d;

   localparam logic [1:0] DEC_UNITS     = 2'd0;
   localparam logic [1:0] DEC_TENS      = 2'd1;
   localparam logic [1:0] DEC_HUNDREDS  = 2'd2;
   localparam logic [1:0] DEC_THOUSANDS = 2'd3;

   typedef struct packed {
      logic       err;
      logic       zero;
      logic [1:0] d3;
      logic [3:0] d2;
      logic [3:0] d1;
      logic [3:0] d0;
   } digits_type;

   typedef struct packed {
      logic [GROUP_CH-1:0][SYMBOL_W-1:0] ch;
      logic [CNT_W-1:0]                  cnt;
   } group_type;

   typedef struct packed {
      logic                err;
      logic                zero;
      group_type [3:0]     grp;
   } letters_type;

   typedef struct packed {
      logic                              err;
      logic                              zero;
      logic [WORD_CH-1:0][SYMBOL_W-1:0]  ch;
      logic [IDX_W-1:0]                  last_idx;
   } word_type;

   // letters of one decimal digit at one decade, most significant first
   function automatic group_type digit_pattern(input logic [3:0] digit,
                                               input logic [1:0] decade);
      group_type             g;
      logic [SYMBOL_W-1:0]   one;
      logic [SYMBOL_W-1:0]   five;
      logic [SYMBOL_W-1:0]   ten;
      case (decade)
         DEC_UNITS: begin
            one = CHAR_I; five = CHAR_V; ten = CHAR_X;
         end
         DEC_TENS: begin
            one = CHAR_X; five = CHAR_L; ten = CHAR_C;
         end
         DEC_HUNDREDS: begin
            one = CHAR_C; five = CHAR_D; ten = CHAR_M;
         end
         default: begin
            one = CHAR_M; five = CHAR_NONE; ten = CHAR_NONE;
         end
      endcase
      g.ch = '0;
      case (digit)
         4'd0: g.cnt = 3'd0;
         4'd1: begin g.cnt = 3'd1; g.ch[0] = one; end
         4'd2: begin g.cnt = 3'd2; g.ch[0] = one; g.ch[1] = one; end
         4'd3: begin
            g.cnt = 3'd3; g.ch[0] = one; g.ch[1] = one; g.ch[2] = one;
         end
         4'd4: begin g.cnt = 3'd2; g.ch[0] = one; g.ch[1] = five; end
         4'd5: begin g.cnt = 3'd1; g.ch[0] = five; end
         4'd6: begin g.cnt = 3'd2; g.ch[0] = five; g.ch[1] = one; end
         4'd7: begin
            g.cnt = 3'd3; g.ch[0] = five; g.ch[1] = one; g.ch[2] = one;
         end
         4'd8: begin
            g.cnt = 3'd4; g.ch[0] = five; g.ch[1] = one; g.ch[2] = one;
            g.ch[3] = one;
         end
         4'd9: begin g.cnt = 3'd2; g.ch[0] = one; g.ch[1] = ten; end
         default: g.cnt = 3'd0;
      endcase
      return g;
   endfunction

endpackage

// File: hw/rtl/itrn_if.sv
// valid/ready channel interfaces for the request and response items
interface itrn_req_if;
   import itrn_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itrn_rsp_if;
   import itrn_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SYMBOL_W-1:0]  symbol;
   logic                 last;
   logic                 empty_res;
   logic                 range_error;

   modport source (output valid, output symbol, output last, output empty_res,
                   output range_error, input ready);
   modport sink   (input valid, input symbol, input last, input empty_res,
                   input range_error, output ready);
endinterface

// File: hw/rtl/itrn_digits.sv
// three stage binary to decimal digit split with range check
module itrn_digits (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [itrn_pkg::VALUE_W-1:0] in_value,
   output logic                                out_valid,
   input  logic                                out_ready,
   output itrn_pkg::digits_type                out_digits
);
   import itrn_pkg::*;

   // stage 1: thousands
   logic        v1_ff;
   logic        err1_ff, err1_in;
   logic        zero1_ff, zero1_in;
   logic [1:0]  d3_1_ff, d3_1_in;
   logic [9:0]  rem1_ff, rem1_in;
   // stage 2: hundreds
   logic        v2_ff;
   logic        err2_ff, zero2_ff;
   logic [1:0]  d3_2_ff;
   logic [3:0]  d2_2_ff, d2_2_in;
   logic [6:0]  rem2_ff, rem2_in;
   // stage 3: tens and units
   logic        v3_ff;
   digits_type  dig3_ff, dig3_in;

   logic        en1, en2, en3;
   logic [11:0] mag;
   logic [11:0] sub1;
   logic [9:0]  sub2;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      mag      = in_value[11:0];
      err1_in  = in_value[VALUE_W-1] || (mag >= VALUE_LIMIT);
      zero1_in = (in_value == '0);
      if (mag >= 12'd3000) begin
         d3_1_in = 2'd3; sub1 = 12'd3000;
      end else if (mag >= 12'd2000) begin
         d3_1_in = 2'd2; sub1 = 12'd2000;
      end else if (mag >= 12'd1000) begin
         d3_1_in = 2'd1; sub1 = 12'd1000;
      end else begin
         d3_1_in = 2'd0; sub1 = 12'd0;
      end
      rem1_in = 10'(mag - sub1);
   end

   // hundreds: independent compares against each multiple of one hundred
   always_comb begin
      d2_2_in = 4'd0;
      for (int h = 1; h < 10; h++) begin
         if (rem1_ff >= 10'(h * 100)) d2_2_in = 4'(h);
      end
      sub2    = 10'(d2_2_in) * 10'd100;
      rem2_in = 7'(rem1_ff - sub2);
   end

   // tens by reciprocal multiply, exact for every 7 bit remainder
   always_comb begin
      prod             = 15'(rem2_ff) * 15'd205;
      tens             = prod[14:11];
      tens_x10         = 7'(tens) * 7'd10;
      dig3_in.err      = err2_ff;
      dig3_in.zero     = zero2_ff;
      dig3_in.d3       = d3_2_ff;
      dig3_in.d2       = d2_2_ff;
      dig3_in.d1       = tens;
      dig3_in.d0       = 4'(rem2_ff - tens_x10);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         err1_ff  <= err1_in;
         zero1_ff <= zero1_in;
         d3_1_ff  <= d3_1_in;
         rem1_ff  <= rem1_in;
      end
      if (en2) begin
         err2_ff  <= err1_ff;
         zero2_ff <= zero1_ff;
         d3_2_ff  <= d3_1_ff;
         d2_2_ff  <= d2_2_in;
         rem2_ff  <= rem2_in;
      end
      if (en3) dig3_ff <= dig3_in;
   end

   assign out_valid  = v3_ff;
   assign out_digits = dig3_ff;

endmodule

// File: hw/rtl/itrn_letters.sv
// two stage digit pattern lookup and packing into one letter word
module itrn_letters (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  itrn_pkg::digits_type in_digits,
   output logic                 out_valid,
   input  logic                 out_ready,
   output itrn_pkg::word_type   out_word
);
   import itrn_pkg::*;

   logic        va_ff, vb_ff;
   logic        ena, enb;
   letters_type let_ff, let_in;
   word_type    word_ff, word_in;

   logic [IDX_W-1:0] o1, o2, o3, total;
   logic [IDX_W-1:0] pos;
   logic [IDX_W-1:0] diff;

   assign enb      = !vb_ff || out_ready;
   assign ena      = !va_ff || enb;
   assign in_ready = ena;

   always_comb begin
      let_in.err    = in_digits.err;
      let_in.zero   = in_digits.zero;
      let_in.grp[3] = digit_pattern({2'b00, in_digits.d3}, DEC_THOUSANDS);
      let_in.grp[2] = digit_pattern(in_digits.d2, DEC_HUNDREDS);
      let_in.grp[1] = digit_pattern(in_digits.d1, DEC_TENS);
      let_in.grp[0] = digit_pattern(in_digits.d0, DEC_UNITS);
   end

   // thousands letters first, then hundreds, tens, units
   always_comb begin
      o1    = IDX_W'(let_ff.grp[3].cnt);
      o2    = o1 + IDX_W'(let_ff.grp[2].cnt);
      o3    = o2 + IDX_W'(let_ff.grp[1].cnt);
      total = o3 + IDX_W'(let_ff.grp[0].cnt);
      word_in.err  = let_ff.err;
      word_in.zero = let_ff.zero;
      word_in.ch   = '0;
      diff         = '0;
      for (int p = 0; p < WORD_CH; p++) begin
         pos = IDX_W'(p);
         if (pos < o1) begin
            word_in.ch[p] = let_ff.grp[3].ch[pos[1:0]];
         end else if (pos < o2) begin
            diff          = pos - o1;
            word_in.ch[p] = let_ff.grp[2].ch[diff[1:0]];
         end else if (pos < o3) begin
            diff          = pos - o2;
            word_in.ch[p] = let_ff.grp[1].ch[diff[1:0]];
         end else if (pos < total) begin
            diff          = pos - o3;
            word_in.ch[p] = let_ff.grp[0].ch[diff[1:0]];
         end
      end
      if (let_ff.err || let_ff.zero) begin
         word_in.ch       = '0;
         word_in.last_idx = '0;
      end else begin
         word_in.last_idx = total - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (ena) va_ff <= in_valid;
         if (enb) vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ena) let_ff  <= let_in;
      if (enb) word_ff <= word_in;
   end

   assign out_valid = vb_ff;
   assign out_word  = word_ff;

endmodule

// File: hw/rtl/itrn_serial.sv
// output stage that sends one letter per response item
module itrn_serial (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  itrn_pkg::word_type in_word,
   itrn_rsp_if.source         rsp_chan
);
   import itrn_pkg::*;

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   word_type         word_ff;
   logic             at_last;
   logic             load;

   assign at_last  = (idx_ff == word_ff.last_idx);
   assign in_ready = !busy_ff || (rsp_chan.ready && at_last);
   assign load     = in_valid && in_ready;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff && rsp_chan.ready) begin
         if (at_last) busy_in = 1'b0;
         else idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) word_ff <= in_word;
   end

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.symbol      = word_ff.ch[idx_ff];
   assign rsp_chan.last        = at_last;
   assign rsp_chan.empty_res   = word_ff.zero && !word_ff.err;
   assign rsp_chan.range_error = word_ff.err;

endmodule

// File: hw/rtl/integer_to_roman_numeral.sv
// integer to roman numeral converter, top level
//
// req_chan carries one signed 13 bit value per item; rsp_chan returns the
// roman numeral one ascii letter per item, thousands first, with last set on
// the final letter of each value
// zero gives a single item with empty_res set, a negative value or one of
// 4000 and above gives a single item with range_error set, both with symbol 0
// the first letter of an item appears once it has passed the three digit
// stages, the two letter stages and the serializer load
// throughput: the serializer sends one letter per cycle while rsp_chan.ready
// is high, and a numeral has 1 to 15 letters (3888 is the longest); the
// serializer loads the next word in the same cycle its last letter is taken,
// so words go out back to back
// the five pipeline stages keep taking items until they fill up behind a
// busy serializer; when the receiver drops rsp_chan.ready each full stage
// with no room ahead holds its item and nothing is lost or sent twice
// synchronous active high reset clears all valid bits and the serializer
module integer_to_roman_numeral (
   input  logic       clock,
   input  logic       reset,
   itrn_req_if.sink   req_chan,
   itrn_rsp_if.source rsp_chan
);
   import itrn_pkg::*;

   // digit split to pattern stage
   logic       dig_valid;
   logic       dig_ready;
   digits_type dig_data;

   // pattern stage to serializer
   logic       word_valid;
   logic       word_ready;
   word_type   word_data;

   itrn_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_value   (req_chan.value),
      .out_valid  (dig_valid),
      .out_ready  (dig_ready),
      .out_digits (dig_data)
   );

   itrn_letters u_letters (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dig_valid),
      .in_ready  (dig_ready),
      .in_digits (dig_data),
      .out_valid (word_valid),
      .out_ready (word_ready),
      .out_word  (word_data)
   );

   // one letter per response item
   itrn_serial u_serial (
      .clock    (clock),
      .reset    (reset),
      .in_valid (word_valid),
      .in_ready (word_ready),
      .in_word  (word_data),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: dv/roman_checker.sv
`timescale 1ns / 100ps
// checker that predicts the roman numeral letters of each value and compares the responses
module roman_checker (
   input  logic clock,
   input  logic reset,
   itrn_req_if  req_mon,
   itrn_rsp_if  rsp_mon,
   output int   fail_count,
   output int   letters_pending,
   output int   values_seen,
   output int   zero_seen,
   output int   error_seen,
   output int   letters_seen
);
   import itrn_pkg::*;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
      logic                empty_res;
      logic                range_error;
   } letter_type;

   letter_type numeral_fifo[$];

   function automatic void push_letter(input logic [SYMBOL_W-1:0] ch);
      letter_type l;
      l.symbol      = ch;
      l.last        = 1'b0;
      l.empty_res   = 1'b0;
      l.range_error = 1'b0;
      numeral_fifo.push_back(l);
   endfunction

   // letters of one value, thousands first, last flag on the final letter
   function automatic void spell_numeral(input logic signed [VALUE_W-1:0] value);
      letter_type          l;
      int                  v;
      int                  scale;
      int                  digit;
      int                  n;
      logic [SYMBOL_W-1:0] one_ch;
      logic [SYMBOL_W-1:0] five_ch;
      logic [SYMBOL_W-1:0] ten_ch;
      v = value;
      if (v < 0 || v >= 4000 || v == 0) begin
         l.symbol      = CHAR_NONE;
         l.last        = 1'b1;
         l.empty_res   = (v == 0);
         l.range_error = (v != 0);
         numeral_fifo.push_back(l);
         return;
      end
      scale = 1000;
      for (int dec = 3; dec >= 0; dec--) begin
         digit = (v / scale) % 10;
         case (dec)
            3: begin
               one_ch = CHAR_M; five_ch = CHAR_NONE; ten_ch = CHAR_NONE;
            end
            2: begin
               one_ch = CHAR_C; five_ch = CHAR_D; ten_ch = CHAR_M;
            end
            1: begin
               one_ch = CHAR_X; five_ch = CHAR_L; ten_ch = CHAR_C;
            end
            default: begin
               one_ch = CHAR_I; five_ch = CHAR_V; ten_ch = CHAR_X;
            end
         endcase
         if (digit == 9) begin
            push_letter(one_ch);
            push_letter(ten_ch);
         end else if (digit >= 5) begin
            push_letter(five_ch);
            for (n = 5; n < digit; n++) push_letter(one_ch);
         end else if (digit == 4) begin
            push_letter(one_ch);
            push_letter(five_ch);
         end else begin
            for (n = 0; n < digit; n++) push_letter(one_ch);
         end
         scale = scale / 10;
      end
      l = numeral_fifo.pop_back();
      l.last = 1'b1;
      numeral_fifo.push_back(l);
   endfunction

   always @(posedge clock) begin
      letter_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            values_seen++;
            if (req_mon.value == 0) zero_seen++;
            else if (req_mon.value < 0 || req_mon.value >= 4000) error_seen++;
            spell_numeral(req_mon.value);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            letters_seen++;
            if (numeral_fifo.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected letter symbol %h last %b empty %b error %b",
                        $time, rsp_mon.symbol, rsp_mon.last, rsp_mon.empty_res,
                        rsp_mon.range_error);
            end else begin
               want = numeral_fifo.pop_front();
               if (rsp_mon.symbol !== want.symbol || rsp_mon.last !== want.last ||
                   rsp_mon.empty_res !== want.empty_res ||
                   rsp_mon.range_error !== want.range_error) begin
                  fail_count++;
                  $display("%0t: letter mismatch: expected symbol %h last %b empty %b error %b",
                           $time, want.symbol, want.last, want.empty_res,
                           want.range_error);
                  $display("%0t:                  got      symbol %h last %b empty %b error %b",
                           $time, rsp_mon.symbol, rsp_mon.last, rsp_mon.empty_res,
                           rsp_mon.range_error);
               end
            end
         end
         letters_pending = numeral_fifo.size();
      end
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, value stimulus, output back-pressure and verdict
module testbench;
   import itrn_pkg::*;

   // generous ceiling, far above the slowest legal run
   localparam int CYCLE_LIMIT    = 200000;
   localparam int ITEMS_PER_MIX  = 54;
   localparam int PRESSURE_ITEMS = 30;
   localparam int HOLD_CYCLES    = 150;
   // drain margin after the last letter
   localparam int DRAIN_CYCLES   = 24;

   logic clock;
   logic reset;

   itrn_req_if req_chan ();
   itrn_rsp_if rsp_chan ();

   int idle_pct;
   int stall_pct;
   int hold_req;
   int cycle_count;

   int fail_count;
   int letters_pending;
   int values_seen;
   int zero_seen;
   int error_seen;
   int letters_seen;

   // extremes, a spread of digits across the decades, zero and both out of range sides
   int directed_values[25] = '{
      0, 1, 3, 4, 5, 2767, 9, 10, 40, 49, 90, 99, 400, 444, 500, 900, 999,
      1000, 1994, 3888, 3999, 4000, 4095, -1, -4096
   };

   integer_to_roman_numeral dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   roman_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .fail_count      (fail_count),
      .letters_pending (letters_pending),
      .values_seen     (values_seen),
      .zero_seen       (zero_seen),
      .error_seen      (error_seen),
      .letters_seen    (letters_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL integer_to_roman_numeral");
         $finish;
      end
   end

   // receiver: random stalls at stall_pct, plus a long hold-off when asked
   initial begin : receiver
      int hold_count;
      int hold_ack;
      hold_count = 0;
      hold_ack   = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_ack) begin
            hold_count = HOLD_CYCLES;
            hold_ack   = hold_req;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // random value: mostly legal numerals, some built digit by digit so that
   // long patterns like eights show up often, then noise, zero and out of range
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int pick;
      int raw;
      pick = $urandom_range(99);
      if (pick < 55)
         raw = $urandom_range(3999, 1);
      else if (pick < 72)
         raw = $urandom_range(3) * 1000 + $urandom_range(9) * 100 +
               $urandom_range(9) * 10 + $urandom_range(9);
      else if (pick < 80)
         raw = $urandom;
      else if (pick < 85)
         raw = 0;
      else if (pick < 93)
         raw = -$urandom_range(4096, 1);
      else
         raw = $urandom_range(4095, 4000);
      return raw[VALUE_W-1:0];
   endfunction

   // called and left at a falling edge; valid stays high across back to back items
   task automatic send_value(input logic signed [VALUE_W-1:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= v;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   initial begin : stimulus
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      hold_req       = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed values with no idling on either side
      foreach (directed_values[i]) send_value(directed_values[i][VALUE_W-1:0]);

      // random values under four idle mixes: none, sender, receiver, both
      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         repeat (ITEMS_PER_MIX) send_value(pick_value());
      end

      // long output hold while items keep coming, fills the pipeline and
      // stalls the input until the receiver lets go
      idle_pct  = 0;
      stall_pct = 0;
      hold_req++;
      repeat (PRESSURE_ITEMS) send_value(pick_value());

      req_chan.valid <= 1'b0;
      while (letters_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d values (%0d zero, %0d out of range) and %0d letters,",
               values_seen, zero_seen, error_seen, letters_seen);
      $display("under four idle mixes and one long output hold");
      if (fail_count == 0 && letters_pending == 0) begin
         $display("PASS integer_to_roman_numeral");
      end else begin
         $display("FAIL integer_to_roman_numeral");
      end
      $finish;
   end

endmodule
